// File: rtl/core/grid_path_count_blocked_cells_core_macros.svh
// Assertion macros for the grid path counter checker.
// No dependencies; included by the checker file only.
`ifndef GRID_PATH_COUNT_BLOCKED_CELLS_CORE_MACROS_SVH
`define GRID_PATH_COUNT_BLOCKED_CELLS_CORE_MACROS_SVH

// Same-cycle implication, disabled in reset
`define GPC_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("gpc check failed");

// Next-cycle implication, disabled in reset
`define GPC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("gpc check failed");

`endif

// File: rtl/core/gpc_pkg.sv
// Shared types for the grid path counter: request and response payloads,
// controller-to-datapath command and status. No dependencies.
package gpc_pkg;

   localparam int COORD_BITS     = 6;
   localparam int OUT_COUNT_BITS = 64;

   typedef struct packed {
      logic [COORD_BITS-1:0] target_row;
      logic [COORD_BITS-1:0] target_col;
      logic [COORD_BITS-1:0] knight_row;
      logic [COORD_BITS-1:0] knight_col;
   } req_type;

   typedef struct packed {
      logic [OUT_COUNT_BITS-1:0] path_count;
      logic                      count_overflow;
   } rsp_type;

   // Controller commands to the datapath
   typedef struct packed {
      logic load;   // capture a request and restart the cell walk
      logic step;   // evaluate the current cell and advance
   } dp_cmd_type;

   // Datapath status back to the controller
   typedef struct packed {
      logic last_cell;   // current cell is the target cell
   } dp_status_type;

endpackage

// File: rtl/core/gpc_ctrl.sv
// Controller state machine of the grid path counter.
// Depends on gpc_pkg for the command and status structs.
module gpc_ctrl
   import gpc_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   output logic          busy,
   output logic          rsp_valid,
   output dp_cmd_type    dp_cmd,
   input  dp_status_type dp_status
);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_RUN  = 3'b010,
      ST_DONE = 3'b100
   } state_type;

   state_type state_ff, state_in;

   // Next state and commands
   always_comb begin
      state_in    = state_ff;
      dp_cmd.load = 1'b0;
      dp_cmd.step = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               dp_cmd.load = 1'b1;
               state_in    = ST_RUN;
            end
         end
         ST_RUN: begin
            dp_cmd.step = 1'b1;
            if (dp_status.last_cell) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = (state_ff == ST_DONE);

endmodule

// File: rtl/core/gpc_datapath.sv
// Datapath of the grid path counter: cell counters, knight block test,
// saturating adder and the one-row buffer. Depends on gpc_pkg.
module gpc_datapath
   import gpc_pkg::*;
#(
   parameter int MAX_COORD  = 63,
   parameter int COUNT_BITS = 64
) (
   input  logic          clock,
   input  logic          reset,
   input  dp_cmd_type    dp_cmd,
   output dp_status_type dp_status,
   input  req_type       req_data,
   output rsp_type       rsp_data
);

   localparam int DEPTH = MAX_COORD + 1;
   localparam int CW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int WW    = (CW > COORD_BITS) ? CW : COORD_BITS;
   localparam logic [WW-1:0]         MAX_W     = WW'(MAX_COORD);
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

   // Request registers and cell walk
   logic [CW-1:0]         target_row_ff, target_col_ff;
   logic [COORD_BITS-1:0] knight_row_ff, knight_col_ff;
   logic [CW-1:0]         row_index_ff, col_index_ff;
   logic                  saturated_ff;
   logic [COUNT_BITS-1:0] left_ff, result_ff;

   // Row buffer
   logic [COUNT_BITS-1:0] row_store [DEPTH];
   logic [COUNT_BITS-1:0] up_rd_ff;
   logic [CW-1:0]         rd_addr;

   logic [WW-1:0]         tr_ext, tc_ext;
   logic [WW-1:0]         row_ext, col_ext, kr_ext, kc_ext;
   logic [WW-1:0]         dr, dc;
   logic                  blocked;
   logic                  start_cell;
   logic                  last_col;
   logic [COUNT_BITS-1:0] up_val, left_val;
   logic [COUNT_BITS:0]   sum_w;
   logic                  sum_sat;
   logic [COUNT_BITS-1:0] cell_val;
   logic                  cell_sat;

   // Clamp target to the grid
   assign tr_ext = WW'(req_data.target_row);
   assign tc_ext = WW'(req_data.target_col);

   // Knight block test on absolute distances
   assign row_ext = WW'(row_index_ff);
   assign col_ext = WW'(col_index_ff);
   assign kr_ext  = WW'(knight_row_ff);
   assign kc_ext  = WW'(knight_col_ff);
   assign dr = (row_ext >= kr_ext) ? (row_ext - kr_ext) : (kr_ext - row_ext);
   assign dc = (col_ext >= kc_ext) ? (col_ext - kc_ext) : (kc_ext - col_ext);
   assign blocked = ((dr == WW'(0)) && (dc == WW'(0))) ||
                    ((dr == WW'(1)) && (dc == WW'(2))) ||
                    ((dr == WW'(2)) && (dc == WW'(1)));

   // Cell value: up from the buffer, left from the previous cell
   assign start_cell = (row_index_ff == '0) && (col_index_ff == '0);
   assign up_val     = (row_index_ff == '0) ? '0 : up_rd_ff;
   assign left_val   = (col_index_ff == '0) ? '0 : left_ff;
   assign sum_w      = {1'b0, up_val} + {1'b0, left_val};
   assign sum_sat    = sum_w[COUNT_BITS];

   always_comb begin
      cell_sat = 1'b0;
      if (start_cell) begin
         cell_val = COUNT_BITS'(1);
      end else if (blocked) begin
         cell_val = '0;
      end else if (sum_sat) begin
         cell_val = COUNT_MAX;
         cell_sat = 1'b1;
      end else begin
         cell_val = sum_w[COUNT_BITS-1:0];
      end
   end

   // Walk position; prefetch the column of the next cell
   assign last_col  = (col_index_ff == target_col_ff);
   assign rd_addr   = last_col ? '0 : (col_index_ff + 1'b1);
   assign dp_status.last_cell = last_col && (row_index_ff == target_row_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         row_index_ff <= '0;
         col_index_ff <= '0;
         saturated_ff <= 1'b0;
      end else if (dp_cmd.load) begin
         row_index_ff <= '0;
         col_index_ff <= '0;
         saturated_ff <= 1'b0;
      end else if (dp_cmd.step) begin
         if (last_col) begin
            col_index_ff <= '0;
            row_index_ff <= row_index_ff + 1'b1;
         end else begin
            col_index_ff <= col_index_ff + 1'b1;
         end
         if (cell_sat) begin
            saturated_ff <= 1'b1;
         end
      end
   end

   // Capture request and hold cell results
   always_ff @(posedge clock) begin
      if (dp_cmd.load) begin
         target_row_ff <= (tr_ext > MAX_W) ? CW'(MAX_COORD) : CW'(tr_ext);
         target_col_ff <= (tc_ext > MAX_W) ? CW'(MAX_COORD) : CW'(tc_ext);
         knight_row_ff <= req_data.knight_row;
         knight_col_ff <= req_data.knight_col;
      end
      if (dp_cmd.step) begin
         left_ff   <= cell_val;
         result_ff <= cell_val;
      end
   end

   // Row buffer: write the cell, read the next column with write bypass
   always_ff @(posedge clock) begin
      if (dp_cmd.step) begin
         row_store[col_index_ff] <= cell_val;
      end
      if (dp_cmd.step && (rd_addr == col_index_ff)) begin
         up_rd_ff <= cell_val;
      end else begin
         up_rd_ff <= row_store[rd_addr];
      end
   end

   assign rsp_data.path_count     = OUT_COUNT_BITS'(result_ff);
   assign rsp_data.count_overflow = saturated_ff;

endmodule

// File: rtl/core/grid_path_count_blocked_cells_core.sv
// Top level of the grid path counter: controller plus datapath.
// Depends on gpc_pkg, gpc_ctrl and gpc_datapath.
//
//   channel   ports                     transfer when
//   request   start, busy, req_data     start high and busy low
//   response  rsp_valid, rsp_data       rsp_valid high (one cycle)
//
// A request walks (tr+1)*(tc+1) cells, one per cycle, bounded by the single
// read and write port of the row buffer; the request is loaded in the idle
// state before the walk, and a done state presents the result (at most 64 by 64 cells).
// Reset is synchronous; the row buffer is not cleared.
// The receiver cannot stall: rsp_valid pulses once per request, and busy
// stays high from the accepted start through the response cycle.
module grid_path_count_blocked_cells_core
   import gpc_pkg::*;
#(
   parameter int MAX_COORD  = 63,
   parameter int COUNT_BITS = 64
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_valid,
   output rsp_type rsp_data
);

   dp_cmd_type    dp_cmd;
   dp_status_type dp_status;

   gpc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .dp_cmd    (dp_cmd),
      .dp_status (dp_status)
   );

   gpc_datapath #(
      .MAX_COORD  (MAX_COORD),
      .COUNT_BITS (COUNT_BITS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .dp_cmd    (dp_cmd),
      .dp_status (dp_status),
      .req_data  (req_data),
      .rsp_data  (rsp_data)
   );

endmodule

// File: rtl/core/gpc_checker.sv
// Port-level checker for the grid path counter and its bind.
// Depends on gpc_pkg and grid_path_count_blocked_cells_core_macros.svh.
`include "grid_path_count_blocked_cells_core_macros.svh"

module gpc_checker
   import gpc_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    start,
   input logic    busy,
   input logic    rsp_valid,
   input rsp_type rsp_data
);

   // Accepted request occupies the block
   `GPC_ASSERT_NEXT(a_accept_busy, clock, reset, start && !busy, busy)
   // Response strobe lasts one cycle
   `GPC_ASSERT_NEXT(a_rsp_pulse, clock, reset, rsp_valid, !rsp_valid)
   // Response only while a request is open
   `GPC_ASSERT_IMPL(a_rsp_in_busy, clock, reset, rsp_valid, busy)
   // Block frees right after the response transfer
   `GPC_ASSERT_NEXT(a_rsp_frees, clock, reset, rsp_valid, !busy)
   // Response payload is fully known on its transfer
   `GPC_ASSERT_IMPL(a_rsp_known, clock, reset, rsp_valid, !$isunknown(rsp_data))

endmodule

bind grid_path_count_blocked_cells_core gpc_checker u_gpc_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_valid (rsp_valid),
   .rsp_data  (rsp_data)
);
